### src/ubxnav_pkg.sv
// Shared constants and types for the navigation frame parser.
package ubxnav_pkg;

    // Frame framing bytes and message codes
    localparam logic [7:0]  SYNC_FIRST   = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND  = 8'h62;
    localparam logic [7:0]  NAV_CLASS    = 8'h01;
    localparam logic [7:0]  ID_POSITION  = 8'h02;
    localparam logic [7:0]  ID_STATUS    = 8'h03;
    localparam logic [7:0]  ID_SOLUTION  = 8'h06;
    localparam logic [7:0]  ID_VELOCITY  = 8'h12;

    // Largest payload length accepted before the frame is dropped
    localparam logic [15:0] MAX_PAYLOAD  = 16'd512;

    // Fix types that count as a valid fix
    localparam logic [7:0]  FIX_2D       = 8'h02;
    localparam logic [7:0]  FIX_3D       = 8'h03;

    // Result kind codes
    localparam logic [2:0]  KIND_POSITION = 3'd0;
    localparam logic [2:0]  KIND_STATUS   = 3'd1;
    localparam logic [2:0]  KIND_SOLUTION = 3'd2;
    localparam logic [2:0]  KIND_VELOCITY = 3'd3;
    localparam logic [2:0]  KIND_OTHER    = 3'd4;

    // Reciprocals: q = (|x| * RECIP) >> SHIFT, exact for |x| <= 2^31
    localparam logic [31:0] ALT_RECIP    = 32'd2199023256;   // ceil(2^41 / 1000)
    localparam int          ALT_SHIFT    = 41;
    localparam logic [31:0] HEAD_RECIP   = 32'd3518437209;   // ceil(2^45 / 10000)
    localparam int          HEAD_SHIFT   = 45;

    // Scaled values handed from the divider to the parser
    typedef struct packed {
        logic signed [22:0] altitude_m;
        logic [15:0]        course;
    } scale_out_t;

endpackage

### src/ubx_navigation_frame_parser.sv
// Top level: byte-stream frame parser that reports navigation values per good class-01 frame.
//
// Takes one received byte per item and can accept a byte in every cycle, but the last
// checksum byte waits on a held result. It hunts for the B5 62 sync pair, reads class,
// id and a little-endian length (lengths above 512 drop the frame), checks the two-byte
// running checksum and, for each good class-01 frame, gives one result item in the cycle
// after the second checksum byte is accepted. Only the payload bytes that feed results are
// kept (offsets 4-11, 16-27 and 47). The altitude and course divisions are reciprocal
// multiplies registered off the kept bytes; they settle during the two checksum bytes, so
// they never limit the rate. Other bytes are accepted even while a result waits on output.
module ubx_navigation_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // latitude, longitude, altitude_m, fix_valid,
                                         // satellites_used, ground_speed, ground_course,
                                         // update_ready, zero fill (lowest first)
    output logic [2:0]   m_axis_tuser    // [2:0] msg_kind
);

    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_SYNC2   = 4'd1,
        ST_CLASS   = 4'd2,
        ST_ID      = 4'd3,
        ST_LEN_LO  = 4'd4,
        ST_LEN_HI  = 4'd5,
        ST_PAYLOAD = 4'd6,
        ST_CSUM_A  = 4'd7,
        ST_CSUM_B  = 4'd8
    } step_t;

    step_t              step_reg, step_next;
    logic [7:0]         class_reg, class_next;
    logic [7:0]         id_reg, id_next;
    logic [15:0]        len_reg, len_next;
    logic [15:0]        count_reg, count_next;
    logic [7:0]         sum_a_reg, sum_a_next;
    logic [7:0]         sum_b_reg, sum_b_next;
    logic [7:0]         store_a_reg [8];    // payload offsets 4..11
    logic [7:0]         store_b_reg [12];   // payload offsets 16..27
    logic [7:0]         sats_byte_reg;      // payload offset 47
    logic               pos_new_reg, pos_new_next;
    logic               vel_new_reg, vel_new_next;
    logic               pending_reg, pending_next;
    logic signed [31:0] lat_reg, lat_next;
    logic signed [31:0] lon_reg, lon_next;
    logic signed [22:0] alt_reg, alt_next;
    logic               fix_reg, fix_next;
    logic [7:0]         sats_reg, sats_next;
    logic [31:0]        speed_reg, speed_next;
    logic [15:0]        course_reg, course_next;
    logic               ready_reg, ready_next;
    logic [2:0]         kind_reg, kind_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_take;
    logic               result;
    logic [7:0]         b;
    logic [7:0]         sum_a_add;
    logic [15:0]        len_full;
    logic [7:0]         hunt_byte;
    step_t              hunt_step;
    logic               status_fix_ok;
    logic               fix_solution;
    logic signed [31:0] alt_raw;
    logic signed [31:0] head_raw;
    ubxnav_pkg::scale_out_t scaled;

    assign b = s_axis_tdata;

    // Only the final checksum byte needs room on the output side
    assign s_axis_tready = (step_reg != ST_CSUM_B) || !out_valid_reg || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign sum_a_add = sum_a_reg + b;
    assign len_full  = {b, len_reg[7:0]};
    assign hunt_byte = b;
    assign hunt_step = (hunt_byte == ubxnav_pkg::SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;

    // Fields read straight from the kept payload bytes
    assign alt_raw  = {store_b_reg[3], store_b_reg[2], store_b_reg[1], store_b_reg[0]};
    assign head_raw = {store_b_reg[11], store_b_reg[10], store_b_reg[9], store_b_reg[8]};

    assign status_fix_ok = store_a_reg[1][0] &&
                           (store_a_reg[0] == ubxnav_pkg::FIX_2D ||
                            store_a_reg[0] == ubxnav_pkg::FIX_3D);
    assign fix_solution  = store_a_reg[7][0] &&
                           (store_a_reg[6] == ubxnav_pkg::FIX_2D ||
                            store_a_reg[6] == ubxnav_pkg::FIX_3D);

    ubxnav_scale u_scale (
        .clk      (clk),
        .alt_raw  (alt_raw),
        .head_raw (head_raw),
        .scaled   (scaled)
    );

    // Frame parser and checksum
    always_comb
    begin
        step_next  = step_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        result     = 1'b0;
        if (in_take)
        begin
            unique case (step_reg)
                ST_SYNC2:
                begin
                    if (b == ubxnav_pkg::SYNC_SECOND)
                    begin
                        step_next = ST_CLASS;
                    end
                    else
                    begin
                        step_next  = hunt_step;
                        count_next = 16'd0;
                    end
                end
                ST_CLASS:
                begin
                    class_next = b;
                    sum_a_next = b;
                    sum_b_next = b;
                    step_next  = ST_ID;
                end
                ST_ID:
                begin
                    id_next    = b;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_reg + sum_a_add;
                    step_next  = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    len_next   = {8'd0, b};
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_reg + sum_a_add;
                    step_next  = ST_LEN_HI;
                end
                ST_LEN_HI:
                begin
                    len_next   = len_full;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_reg + sum_a_add;
                    if (len_full > ubxnav_pkg::MAX_PAYLOAD)
                    begin
                        step_next  = hunt_step;
                        count_next = 16'd0;
                    end
                    else if (len_full == 16'd0)
                    begin
                        step_next = ST_CSUM_A;
                    end
                    else
                    begin
                        step_next = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD:
                begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_reg + sum_a_add;
                    count_next = count_reg + 16'd1;
                    if (count_reg + 16'd1 == len_reg)
                    begin
                        step_next = ST_CSUM_A;
                    end
                end
                ST_CSUM_A:
                begin
                    if (sum_a_reg != b)
                    begin
                        step_next  = hunt_step;
                        count_next = 16'd0;
                    end
                    else
                    begin
                        step_next = ST_CSUM_B;
                    end
                end
                ST_CSUM_B:
                begin
                    step_next = ST_HUNT;
                    result    = (sum_b_reg == b) && (class_reg == ubxnav_pkg::NAV_CLASS);
                end
                default:
                begin
                    step_next  = hunt_step;
                    count_next = 16'd0;
                end
            endcase
        end
    end

    // Held navigation values, updated once per good frame
    always_comb
    begin
        pos_new_next = pos_new_reg;
        vel_new_next = vel_new_reg;
        pending_next = pending_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        alt_next     = alt_reg;
        fix_next     = fix_reg;
        sats_next    = sats_reg;
        speed_next   = speed_reg;
        course_next  = course_reg;
        kind_next    = kind_reg;
        ready_next   = ready_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (result)
        begin
            out_valid_next = 1'b1;
            ready_next     = 1'b0;
            unique case (id_reg)
                ubxnav_pkg::ID_POSITION:
                begin
                    kind_next    = ubxnav_pkg::KIND_POSITION;
                    lon_next     = {store_a_reg[3], store_a_reg[2], store_a_reg[1], store_a_reg[0]};
                    lat_next     = {store_a_reg[7], store_a_reg[6], store_a_reg[5], store_a_reg[4]};
                    alt_next     = scaled.altitude_m;
                    fix_next     = pending_reg;
                    pos_new_next = 1'b1;
                end
                ubxnav_pkg::ID_STATUS:
                begin
                    kind_next    = ubxnav_pkg::KIND_STATUS;
                    pending_next = status_fix_ok;
                    if (!status_fix_ok)
                    begin
                        fix_next = 1'b0;
                    end
                end
                ubxnav_pkg::ID_SOLUTION:
                begin
                    kind_next    = ubxnav_pkg::KIND_SOLUTION;
                    pending_next = fix_solution;
                    if (!fix_solution)
                    begin
                        fix_next = 1'b0;
                    end
                    sats_next = sats_byte_reg;
                end
                ubxnav_pkg::ID_VELOCITY:
                begin
                    kind_next    = ubxnav_pkg::KIND_VELOCITY;
                    speed_next   = {store_b_reg[7], store_b_reg[6], store_b_reg[5], store_b_reg[4]};
                    course_next  = scaled.course;
                    vel_new_next = 1'b1;
                end
                default:
                begin
                    kind_next = ubxnav_pkg::KIND_OTHER;
                end
            endcase
            if (pos_new_next && vel_new_next)
            begin
                pos_new_next = 1'b0;
                vel_new_next = 1'b0;
                ready_next   = 1'b1;
            end
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_HUNT;
            class_reg     <= 8'd0;
            id_reg        <= 8'd0;
            len_reg       <= 16'd0;
            count_reg     <= 16'd0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            pos_new_reg   <= 1'b0;
            vel_new_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            lat_reg       <= '0;
            lon_reg       <= '0;
            alt_reg       <= '0;
            fix_reg       <= 1'b0;
            sats_reg      <= 8'd0;
            speed_reg     <= 32'd0;
            course_reg    <= 16'd0;
            ready_reg     <= 1'b0;
            kind_reg      <= ubxnav_pkg::KIND_POSITION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            class_reg     <= class_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            pos_new_reg   <= pos_new_next;
            vel_new_reg   <= vel_new_next;
            pending_reg   <= pending_next;
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            alt_reg       <= alt_next;
            fix_reg       <= fix_next;
            sats_reg      <= sats_next;
            speed_reg     <= speed_next;
            course_reg    <= course_next;
            ready_reg     <= ready_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Kept payload bytes, each written when the payload count reaches its offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                store_a_reg[i] <= 8'd0;
            end
            for (int i = 0; i < 12; i++)
            begin
                store_b_reg[i] <= 8'd0;
            end
            sats_byte_reg <= 8'd0;
        end
        else if (in_take && step_reg == ST_PAYLOAD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (count_reg == 16'(i + 4))
                begin
                    store_a_reg[i] <= b;
                end
            end
            for (int i = 0; i < 12; i++)
            begin
                if (count_reg == 16'(i + 16))
                begin
                    store_b_reg[i] <= b;
                end
            end
            if (count_reg == 16'd47)
            begin
                sats_byte_reg <= b;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {7'd0, ready_reg, course_reg, speed_reg, sats_reg, fix_reg,
                            alt_reg, lon_reg, lat_reg};

endmodule

### src/ubxnav_scale.sv
// Constant dividers: altitude mm to m and heading to course, one registered product each.
module ubxnav_scale (
    input  logic                  clk,
    input  logic signed [31:0]    alt_raw,
    input  logic signed [31:0]    head_raw,
    output ubxnav_pkg::scale_out_t scaled
);

    logic [31:0]        alt_mag;
    logic [31:0]        head_mag;
    logic [63:0]        alt_prod_reg;
    logic [63:0]        head_prod_reg;
    logic               alt_neg_reg;
    logic               head_neg_reg;
    logic [21:0]        alt_quot;
    logic [17:0]        head_quot;
    logic [17:0]        head_signed;

    // Magnitudes of the signed inputs; the most negative value maps to 2^31
    assign alt_mag  = alt_raw[31]  ? (~alt_raw + 32'd1)  : alt_raw;
    assign head_mag = head_raw[31] ? (~head_raw + 32'd1) : head_raw;

    // Reciprocal products, registered
    always_ff @(posedge clk)
    begin
        alt_prod_reg  <= {32'd0, alt_mag} * {32'd0, ubxnav_pkg::ALT_RECIP};
        head_prod_reg <= {32'd0, head_mag} * {32'd0, ubxnav_pkg::HEAD_RECIP};
        alt_neg_reg   <= alt_raw[31];
        head_neg_reg  <= head_raw[31];
    end

    // Quotient magnitudes, then truncation toward zero by restoring the sign
    assign alt_quot  = alt_prod_reg[ubxnav_pkg::ALT_SHIFT +: 22];
    assign head_quot = head_prod_reg[ubxnav_pkg::HEAD_SHIFT +: 18];

    assign head_signed = head_neg_reg ? (~head_quot + 18'd1) : head_quot;

    always_comb
    begin
        scaled.altitude_m = alt_neg_reg ? -$signed({1'b0, alt_quot}) : $signed({1'b0, alt_quot});
        scaled.course     = head_signed[15:0];
    end

endmodule
